@@ design/mspg_pkg.sv @@
`timescale 1ns / 1ps
// Types, request codes, register indexes and reset values of the servo pulse generator.
// Also holds the constant divide-by-180 used when a frame starts. No dependencies.
package mspg_pkg;

  // channel count and field widths
  localparam int NUM_SERVOS = 9;
  localparam int ID_W       = 4;
  localparam int ANGLE_W    = 8;
  localparam int COUNT_W    = 16;
  localparam int PULSE_W    = 12;
  localparam int WIDTH_W    = 13;
  localparam int PROD_W     = ANGLE_W + PULSE_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // request codes
  localparam logic [2:0] REQ_TICK   = 3'd0;
  localparam logic [2:0] REQ_ATTACH = 3'd1;
  localparam logic [2:0] REQ_DETACH = 3'd2;
  localparam logic [2:0] REQ_WRITE  = 3'd3;
  localparam logic [2:0] REQ_READ   = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPAN   = 2'd3;

  // register reset values
  localparam logic [COUNT_W-1:0] PERIOD_RESET = 16'd20000;
  localparam logic [PULSE_W-1:0] MIN_RESET    = 12'd500;
  localparam logic [PULSE_W-1:0] SPAN_RESET   = 12'd2000;

  // angle limits and the code for an unattached read
  localparam logic [ANGLE_W-1:0] ANGLE_MAX         = 8'd180;
  localparam logic [ANGLE_W-1:0] NOT_ATTACHED_CODE = 8'd255;
  localparam logic [ID_W:0]      SERVO_ID_LIMIT    = (ID_W+1)'(NUM_SERVOS);

  // 180 = 4 * 45: drop two bits, then multiply by ceil(2^24 / 45)
  localparam int                 RECIP_SHIFT = 24;
  localparam int                 RECIP_W     = 19;
  localparam logic [RECIP_W-1:0] RECIP_45    = 19'd372828;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [ID_W-1:0]    servo_id;
    logic [ANGLE_W-1:0] angle;
  } req_t;

  typedef struct packed {
    logic                  ok;
    logic [ANGLE_W-1:0]    read_value;
    logic [NUM_SERVOS-1:0] pin_levels;
  } rsp_t;

  // floor(p / 180), exact for every product of an angle up to 180 and a 12-bit span
  function automatic logic [PULSE_W-1:0] div180(input logic [PROD_W-1:0] p);
    logic [PROD_W-3:0]           quarter;
    logic [PROD_W-2+RECIP_W-1:0] scaled;
    quarter = p[PROD_W-1:2];
    scaled  = (PROD_W-2+RECIP_W)'(quarter) * (PROD_W-2+RECIP_W)'(RECIP_45);
    return scaled[RECIP_SHIFT+PULSE_W-1:RECIP_SHIFT];
  endfunction

endpackage

@@ design/multichannel_servo_pulse_generator_core.sv @@
`timescale 1ns / 1ps
// Nine-channel servo pulse generator: period counter, per-channel pulse state and
// request handling with a two-entry response buffer. Depends on mspg_pkg.

// One request is taken every cycle while req_stall is low. Its response is registered in
// the response register, or in the spare entry while the main one is held by rsp_stall.
// The response side has a main register and one spare entry: req_stall rises
// only once both are full, so a stalled consumer costs the producer nothing until then.
// Each channel keeps angle * span ready in a register, updated as the angle or span
// changes; at a frame start the new pulse width is that product times a fixed
// reciprocal of 180 plus the minimum width, all nine channels in parallel. Registers
// are written through cfg_we / cfg_index / cfg_data and must only be written while
// no request is in flight.
module multichannel_servo_pulse_generator_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [mspg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mspg_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                req_valid,
  output logic                                req_stall,
  input  mspg_pkg::req_t                      req,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output mspg_pkg::rsp_t                      rsp
);
  import mspg_pkg::*;

  // configuration registers
  logic               enable, enable_next;
  logic [COUNT_W-1:0] period_us, period_us_next;
  logic [PULSE_W-1:0] min_pulse_us, min_pulse_us_next;
  logic [PULSE_W-1:0] span_us, span_us_next;

  // channel state
  logic [COUNT_W-1:0]    frame_count, frame_count_next;
  logic [NUM_SERVOS-1:0] attached, attached_next;
  logic [NUM_SERVOS-1:0] pulse_level, pulse_level_next;
  logic [ANGLE_W-1:0]    angle_store [NUM_SERVOS];
  logic [ANGLE_W-1:0]    angle_store_next [NUM_SERVOS];
  logic [WIDTH_W-1:0]    latched_width [NUM_SERVOS];
  logic [WIDTH_W-1:0]    latched_width_next [NUM_SERVOS];
  logic [PROD_W-1:0]     scaled_prod [NUM_SERVOS];
  logic [PROD_W-1:0]     scaled_prod_next [NUM_SERVOS];

  // response buffer
  logic rsp_valid_next;
  logic skid_valid, skid_valid_next;
  rsp_t skid, skid_next, rsp_next, result;

  // request decode
  logic                  accept;
  logic                  id_ok;
  logic [NUM_SERVOS-1:0] sel;
  logic                  sel_attached;
  logic [ANGLE_W-1:0]    sel_angle;
  logic                  wrap;
  logic [COUNT_W:0]      count_inc;

  assign accept    = req_valid && !req_stall;
  assign req_stall = skid_valid;
  assign id_ok     = {1'b0, req.servo_id} < SERVO_ID_LIMIT;
  assign wrap      = (frame_count == '0);
  assign count_inc = {1'b0, frame_count} + (COUNT_W+1)'(1);

  // addressed channel
  always_comb begin
    sel_attached = 1'b0;
    sel_angle    = '0;
    for (int i = 0; i < NUM_SERVOS; i++) begin
      sel[i] = id_ok && (req.servo_id == ID_W'(i));
      if (sel[i]) begin
        sel_attached = attached[i];
        sel_angle    = angle_store[i];
      end
    end
  end

  // request handling, counter, pulse edges and register writes
  always_comb begin
    enable_next       = enable;
    period_us_next    = period_us;
    min_pulse_us_next = min_pulse_us;
    span_us_next      = span_us;
    frame_count_next  = frame_count;
    attached_next     = attached;
    pulse_level_next  = pulse_level;
    angle_store_next  = angle_store;
    latched_width_next = latched_width;
    result            = '0;

    if (accept) begin
      case (req.req_type)
        REQ_TICK: begin
          result.ok = 1'b1;
          if (enable) begin
            for (int i = 0; i < NUM_SERVOS; i++) begin
              if (wrap && attached[i]) begin
                // frame start: raise and latch; a zero width drops at once
                latched_width_next[i] = WIDTH_W'(min_pulse_us) +
                                        WIDTH_W'(div180(scaled_prod[i]));
                pulse_level_next[i]   = !((min_pulse_us == '0) &&
                                          (scaled_prod[i] < PROD_W'(ANGLE_MAX)));
              end else if (pulse_level[i] &&
                           ({{(COUNT_W-WIDTH_W){1'b0}}, latched_width[i]} == frame_count)) begin
                pulse_level_next[i] = 1'b0;
              end
            end
            frame_count_next = (count_inc >= {1'b0, period_us}) ? '0 : count_inc[COUNT_W-1:0];
          end
        end
        REQ_ATTACH: begin
          if (id_ok && !sel_attached) begin
            attached_next = attached | sel;
            result.ok     = 1'b1;
          end
        end
        REQ_DETACH: begin
          if (sel_attached) begin
            for (int i = 0; i < NUM_SERVOS; i++) begin
              if (sel[i]) begin
                attached_next[i]      = 1'b0;
                pulse_level_next[i]   = 1'b0;
                angle_store_next[i]   = '0;
                latched_width_next[i] = '0;
              end
            end
            result.ok = 1'b1;
          end
        end
        REQ_WRITE: begin
          if (sel_attached && (req.angle <= ANGLE_MAX)) begin
            for (int i = 0; i < NUM_SERVOS; i++) begin
              if (sel[i]) begin
                angle_store_next[i] = req.angle;
              end
            end
            result.ok = 1'b1;
          end
        end
        REQ_READ: begin
          if (sel_attached) begin
            result.read_value = sel_angle;
            result.ok         = 1'b1;
          end else begin
            result.read_value = NOT_ATTACHED_CODE;
          end
        end
        default: begin
        end
      endcase
    end

    // register writes; disabling stops the frame and drops every pin
    if (cfg_we) begin
      case (cfg_index)
        CFG_ENABLE: begin
          enable_next = cfg_data[0];
          if (!cfg_data[0]) begin
            frame_count_next = '0;
            pulse_level_next = '0;
          end
        end
        CFG_PERIOD: period_us_next    = cfg_data[COUNT_W-1:0];
        CFG_MIN:    min_pulse_us_next = cfg_data[PULSE_W-1:0];
        CFG_SPAN:   span_us_next      = cfg_data[PULSE_W-1:0];
        default: begin
        end
      endcase
    end

    result.pin_levels = enable_next ? pulse_level_next : '0;

    // keep angle * span ready for the next frame start
    for (int i = 0; i < NUM_SERVOS; i++) begin
      scaled_prod_next[i] = PROD_W'(angle_store_next[i]) * PROD_W'(span_us_next);
    end
  end

  // response buffer: main register first, spare entry only while the main one is stalled
  always_comb begin
    rsp_valid_next  = rsp_valid;
    rsp_next        = rsp;
    skid_valid_next = skid_valid;
    skid_next       = skid;
    if (!rsp_valid || !rsp_stall) begin
      if (skid_valid) begin
        rsp_next        = skid;
        rsp_valid_next  = 1'b1;
        skid_valid_next = 1'b0;
      end else begin
        rsp_next       = result;
        rsp_valid_next = accept;
      end
    end else if (accept) begin
      skid_next       = result;
      skid_valid_next = 1'b1;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    rsp  <= rsp_next;
    skid <= skid_next;
    if (rst) begin
      enable       <= 1'b0;
      period_us    <= PERIOD_RESET;
      min_pulse_us <= MIN_RESET;
      span_us      <= SPAN_RESET;
      frame_count  <= '0;
      attached     <= '0;
      pulse_level  <= '0;
      rsp_valid    <= 1'b0;
      skid_valid   <= 1'b0;
      for (int i = 0; i < NUM_SERVOS; i++) begin
        angle_store[i]   <= '0;
        latched_width[i] <= '0;
        scaled_prod[i]   <= '0;
      end
    end else begin
      enable        <= enable_next;
      period_us     <= period_us_next;
      min_pulse_us  <= min_pulse_us_next;
      span_us       <= span_us_next;
      frame_count   <= frame_count_next;
      attached      <= attached_next;
      pulse_level   <= pulse_level_next;
      rsp_valid     <= rsp_valid_next;
      skid_valid    <= skid_valid_next;
      angle_store   <= angle_store_next;
      latched_width <= latched_width_next;
      scaled_prod   <= scaled_prod_next;
    end
  end

  // the spare entry is only ever filled behind a held response
  a_skid_behind_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> rsp_valid)
    else $error("spare response entry holds a request while the main register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(rsp_valid && rsp_stall))
    else $error("spare response entry filled while the main register was free");

  // a disabled block drives no pulses
  a_disabled_pins_low: assert property (@(posedge clk) disable iff (rst)
    !enable |-> (pulse_level == '0))
    else $error("pulse high while the generator is disabled");

  // only attached channels can pulse
  a_detached_low: assert property (@(posedge clk) disable iff (rst)
    (pulse_level & ~attached) == '0)
    else $error("pulse high on a detached channel");

endmodule
